FILE: design/fpfa_pkg.sv
// Shared codes and types for the fixed partition fit allocator.
// No dependencies; imported by the search cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fpfa_pkg;

    localparam int CFG_WIDTH      = 5;
    localparam int POLICY_WIDTH   = 2;
    localparam int COUNT_WIDTH    = 5;
    localparam int IN_INDEX_WIDTH = 4;
    localparam int IN_SIZE_WIDTH  = 16;
    localparam int OUT_IDX_WIDTH  = 4;

    // configuration register indexes
    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    // placement policies; the unused code behaves as first fit
    localparam logic [POLICY_WIDTH-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_WIDTH-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_WIDTH-1:0] POLICY_WORST = 2'd2;

    // input item kinds
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 5'd16;

    // broadcast from the top level to every cell of the chain
    typedef struct packed {
        logic [POLICY_WIDTH-1:0] policy;
        logic [COUNT_WIDTH-1:0]  count;
        logic                    clear_used;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/fixed_partition_fit_allocator.sv
// Top level of the fixed partition fit allocator: configuration registers,
// stream handshakes and the chain of fpfa_cell partitions. Uses fpfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A load transaction writes one partition size and gives no result, so
// loads can follow back to back. A request transaction walks a candidate
// down a chain of NUM_BLOCKS cells, one cell per cycle. Its result passes
// from the last cell register through a pending register into the output
// register. The input takes the next transaction once the result has left
// the pending register for the output register. One request is in the
// chain at a time, and the next
// transaction is taken while the previous result still waits on the output
// side. If a second result leaves the chain while the output register is
// still full, it is held and the input stalls until the output drains. Ties
// go to the lowest index; a request with tlast set frees every partition
// after it is served.
module fixed_partition_fit_allocator
    import fpfa_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [23:0]          s_axis_tdata,  // block_index[3:0], item_size[19:4]
    input  wire logic                 s_axis_tuser,  // mode
    input  wire logic                 s_axis_tlast,  // last_request
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata   // granted[0], granted_index[4:1]
);

    localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    logic [POLICY_WIDTH-1:0]   policy_reg;
    logic [COUNT_WIDTH-1:0]    count_reg;
    logic                      busy_reg;
    logic                      last_reg;
    logic                      pend_valid_reg;
    logic                      pend_found_reg;
    logic [IDX_BITS-1:0]       pend_pick_reg;
    logic                      out_valid_reg;
    logic                      out_granted_reg;
    logic [OUT_IDX_WIDTH-1:0]  out_index_reg;

    logic                      accept;
    logic                      req_go;
    logic                      load_go;
    logic                      exit_valid;
    logic                      out_load;
    logic [IN_INDEX_WIDTH-1:0] in_index;
    logic [SIZE_BITS-1:0]      in_size;
    cell_ctrl_t                ctrl;

    logic                      chain_valid     [NUM_BLOCKS];
    logic                      chain_found     [NUM_BLOCKS];
    logic [IDX_BITS-1:0]       chain_pick      [NUM_BLOCKS];
    logic [SIZE_BITS-1:0]      chain_pick_size [NUM_BLOCKS];
    logic [SIZE_BITS-1:0]      chain_req_size  [NUM_BLOCKS];

    assign in_index = s_axis_tdata[3:0];
    assign in_size  = SIZE_BITS'(s_axis_tdata[19:4]);

    assign s_axis_tready = !busy_reg && !pend_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req_go        = accept && (s_axis_tuser == MODE_REQUEST);
    assign load_go       = accept && (s_axis_tuser == MODE_LOAD);
    assign exit_valid    = chain_valid[NUM_BLOCKS-1];
    assign out_load      = pend_valid_reg && (!out_valid_reg || m_axis_tready);

    assign ctrl.policy     = policy_reg;
    assign ctrl.count      = count_reg;
    assign ctrl.clear_used = exit_valid && last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIRST;
            count_reg  <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY: policy_reg <= cfg_wdata[POLICY_WIDTH-1:0];
                CFG_COUNT:  count_reg  <= cfg_wdata[COUNT_WIDTH-1:0];
                default:    policy_reg <= policy_reg;
            endcase
        end
    end

    // hold the request until its candidate leaves the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_go)
                busy_reg <= 1'b1;
            else if (exit_valid)
                busy_reg <= 1'b0;

            if (exit_valid)
                pend_valid_reg <= 1'b1;
            else if (out_load)
                pend_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_go)
        begin
            last_reg <= s_axis_tlast;
        end
        if (exit_valid)
        begin
            pend_found_reg <= chain_found[NUM_BLOCKS-1];
            pend_pick_reg  <= chain_pick[NUM_BLOCKS-1];
        end
        if (out_load)
        begin
            out_granted_reg <= pend_found_reg;
            out_index_reg   <= pend_found_reg ? OUT_IDX_WIDTH'(pend_pick_reg) : '0;
        end
    end

    for (genvar i = 0; i < NUM_BLOCKS; i++)
    begin : g_cell
        logic                 load_hit;
        logic                 mark_hit;
        logic                 in_valid;
        logic                 in_found;
        logic [IDX_BITS-1:0]  in_pick;
        logic [SIZE_BITS-1:0] in_pick_size;
        logic [SIZE_BITS-1:0] in_req_size;

        assign load_hit = load_go && (32'(in_index) == i);
        assign mark_hit = exit_valid && chain_found[NUM_BLOCKS-1]
                          && (chain_pick[NUM_BLOCKS-1] == IDX_BITS'(i));

        if (i == 0)
        begin : g_head
            assign in_valid     = req_go;
            assign in_found     = 1'b0;
            assign in_pick      = '0;
            assign in_pick_size = '0;
            assign in_req_size  = in_size;
        end
        else
        begin : g_link
            assign in_valid     = chain_valid[i-1];
            assign in_found     = chain_found[i-1];
            assign in_pick      = chain_pick[i-1];
            assign in_pick_size = chain_pick_size[i-1];
            assign in_req_size  = chain_req_size[i-1];
        end

        fpfa_cell #(
            .CELL_INDEX (i),
            .SIZE_BITS  (SIZE_BITS),
            .IDX_BITS   (IDX_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .load_hit      (load_hit),
            .load_size     (in_size),
            .mark_hit      (mark_hit),
            .in_valid      (in_valid),
            .in_found      (in_found),
            .in_pick       (in_pick),
            .in_pick_size  (in_pick_size),
            .in_req_size   (in_req_size),
            .out_valid     (chain_valid[i]),
            .out_found     (chain_found[i]),
            .out_pick      (chain_pick[i]),
            .out_pick_size (chain_pick_size[i]),
            .out_req_size  (chain_req_size[i])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_index_reg, out_granted_reg};

endmodule

`default_nettype wire

FILE: design/fpfa_cell.sv
// One partition of the allocator: holds its size and used flag and refines
// the search candidate that passes through it. Depends on fpfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpfa_cell
    import fpfa_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_BITS   = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cell_ctrl_t           ctrl,
    input  wire logic                 load_hit,
    input  wire logic [SIZE_BITS-1:0] load_size,
    input  wire logic                 mark_hit,
    input  wire logic                 in_valid,
    input  wire logic                 in_found,
    input  wire logic [IDX_BITS-1:0]  in_pick,
    input  wire logic [SIZE_BITS-1:0] in_pick_size,
    input  wire logic [SIZE_BITS-1:0] in_req_size,
    output logic                      out_valid,
    output logic                      out_found,
    output logic [IDX_BITS-1:0]       out_pick,
    output logic [SIZE_BITS-1:0]      out_pick_size,
    output logic [SIZE_BITS-1:0]      out_req_size
);

    logic [SIZE_BITS-1:0] size_reg;
    logic                 used_reg;
    logic                 used_next;
    logic                 valid_reg;
    logic                 found_reg;
    logic                 found_next;
    logic [IDX_BITS-1:0]  pick_reg;
    logic [IDX_BITS-1:0]  pick_next;
    logic [SIZE_BITS-1:0] pick_size_reg;
    logic [SIZE_BITS-1:0] pick_size_next;
    logic [SIZE_BITS-1:0] req_size_reg;
    logic                 in_range;
    logic                 fits;
    logic                 take;

    assign in_range = 32'(ctrl.count) > CELL_INDEX;
    assign fits     = in_range && !used_reg && (size_reg >= in_req_size);

    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            priority if (!in_found)
                take = 1'b1;
            else if (ctrl.policy == POLICY_BEST)
                take = size_reg < in_pick_size;
            else if (ctrl.policy == POLICY_WORST)
                take = size_reg > in_pick_size;
            else
                take = 1'b0;
        end
        found_next     = in_found || take;
        pick_next      = take ? IDX_BITS'(CELL_INDEX) : in_pick;
        pick_size_next = take ? size_reg : in_pick_size;
    end

    always_comb
    begin
        used_next = used_reg;
        priority if (ctrl.clear_used)
            used_next = 1'b0;
        else if (load_hit)
            used_next = 1'b0;
        else if (mark_hit)
            used_next = 1'b1;
        else
            used_next = used_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            size_reg <= load_size;
        end
        if (in_valid)
        begin
            found_reg     <= found_next;
            pick_reg      <= pick_next;
            pick_size_reg <= pick_size_next;
            req_size_reg  <= in_req_size;
        end
    end

    assign out_valid     = valid_reg;
    assign out_found     = found_reg;
    assign out_pick      = pick_reg;
    assign out_pick_size = pick_size_reg;
    assign out_req_size  = req_size_reg;

endmodule

`default_nettype wire
